@@ sv/xed_pkg.sv @@
`default_nettype none
package xed_pkg;

    localparam int MAX_NAME_CHARS = 15;
    localparam int LEN_W          = $clog2(MAX_NAME_CHARS + 1);

    localparam int             CP_W    = 21;
    localparam int             SUM_W   = CP_W + 4;
    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SAT = 21'h1FFFFF;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

    localparam int                 LIMIT_W     = 24;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd2097152;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_XL   = 8'h78;
    localparam logic [7:0] CH_XU   = 8'h58;

    localparam int NUM_NAMES = 5;

    typedef enum logic [2:0] {
        ST_OK,
        ST_ENTITY,
        ST_NAME,
        ST_NUMBER,
        ST_CODEPOINT,
        ST_LIMIT
    } t_status;

    typedef enum logic [2:0] {
        ENT_AMP,
        ENT_LT,
        ENT_GT,
        ENT_QUOT,
        ENT_APOS
    } t_ent;

    // One queue entry: up to four UTF-8 bytes of a code point and an optional status.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic [2:0]      cnt;
        logic            fin;
        t_status         status;
    } t_cmd;

    function automatic logic [2:0] ent_len(input t_ent id);
        logic [2:0] r;
        unique case (id)
            ENT_AMP:  r = 3'd3;
            ENT_LT:   r = 3'd2;
            ENT_GT:   r = 3'd2;
            ENT_QUOT: r = 3'd4;
            ENT_APOS: r = 3'd4;
            default:  r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ent_value(input t_ent id);
        logic [7:0] r;
        unique case (id)
            ENT_AMP:  r = 8'h26;
            ENT_LT:   r = 8'h3C;
            ENT_GT:   r = 8'h3E;
            ENT_QUOT: r = 8'h22;
            ENT_APOS: r = 8'h27;
            default:  r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ent_char(input t_ent id, input logic [1:0] pos);
        logic [31:0] s;
        unique case (id)
            ENT_AMP:  s = {8'h00, "pma"};
            ENT_LT:   s = {16'h0000, "tl"};
            ENT_GT:   s = {16'h0000, "tg"};
            ENT_QUOT: s = "touq";
            ENT_APOS: s = "sopa";
            default:  s = 32'h0;
        endcase
        return s[pos*8 +: 8];
    endfunction

    // Byte idx of the cnt-byte UTF-8 form of cp.
    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [2:0] cnt,
                                             input logic [2:0] idx);
        logic [2:0] sh;
        logic [7:0] r;
        sh = cnt - idx - 3'd1;
        if (idx == 3'd0) begin
            unique case (cnt)
                3'd2:    r = 8'hC0 | 8'(cp >> 6);
                3'd3:    r = 8'hE0 | 8'(cp >> 12);
                3'd4:    r = 8'hF0 | 8'(cp >> 18);
                default: r = cp[7:0];
            endcase
        end else begin
            r = 8'h80 | (8'(cp >> (6 * sh)) & 8'h3F);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/xed_in_if.sv @@
`default_nettype none
interface xed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface
`default_nettype wire

@@ sv/xed_out_if.sv @@
`default_nettype none
interface xed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_data;
    logic       final_res;
    logic [2:0] status;

    modport source (output valid, output out_byte, output is_data, output final_res,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input is_data, input final_res,
                    input status, output ready);
endinterface
`default_nettype wire

@@ sv/xed_front.sv @@
`default_nettype none
module xed_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [xed_pkg::LIMIT_W-1:0]    i_cfg_wdata,
    xed_in_if.sink                              i_in,
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output xed_pkg::t_cmd                       o_cmd
);

    localparam int LW = xed_pkg::LEN_W;
    localparam int CW = xed_pkg::CP_W;
    localparam int SW = xed_pkg::SUM_W;

    logic                            r_in_entity, n_in_entity;
    logic [LW-1:0]                   r_len, n_len;
    logic [xed_pkg::NUM_NAMES-1:0]   r_match, n_match;
    logic                            r_hash, n_hash;
    logic                            r_x2, n_x2;
    logic                            r_dec_bad, n_dec_bad;
    logic                            r_dec_ovf, n_dec_ovf;
    logic [CW-1:0]                   r_dec_val, n_dec_val;
    logic                            r_hex_bad, n_hex_bad;
    logic                            r_hex_ovf, n_hex_ovf;
    logic [CW-1:0]                   r_hex_val, n_hex_val;
    logic [xed_pkg::LIMIT_W-1:0]     r_bytes_out, n_bytes_out;
    xed_pkg::t_status                r_err, n_err;
    logic [xed_pkg::LIMIT_W-1:0]     r_limit;

    logic          accept;
    logic [7:0]    c;
    logic          dec_ok, hex_ok;
    logic [3:0]    dec_d, hex_d;
    logic [SW-1:0] dec_sum, hex_sum;
    logic          named_hit;
    logic [7:0]    named_byte;
    logic          hexmode, bad_num, ovf_sel;
    logic [CW-1:0] cp_sel;
    logic [2:0]    cp_n;
    logic          over_limit;
    xed_pkg::t_cmd cmd;

    assign accept     = i_in.valid && !i_q_full;
    assign i_in.ready = !i_q_full;
    assign c          = i_in.in_byte;

    always_comb begin
        dec_ok = (c >= "0") && (c <= "9");
        dec_d  = c[3:0];
        hex_ok = 1'b1;
        if ((c >= "0") && (c <= "9")) begin
            hex_d = c[3:0];
        end else if (((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"))) begin
            hex_d = c[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
            hex_d  = 4'd0;
        end
        dec_sum = (SW'(r_dec_val) << 3) + (SW'(r_dec_val) << 1) + SW'(dec_d);
        hex_sum = (SW'(r_hex_val) << 4) + SW'(hex_d);
    end

    // Entity close: named lookup, then the numeric checks on the accumulated value.
    always_comb begin
        named_hit  = 1'b0;
        named_byte = 8'h00;
        for (int i = 0; i < xed_pkg::NUM_NAMES; i++) begin
            if (r_match[i] &&
                r_len == LW'(xed_pkg::ent_len(xed_pkg::t_ent'(3'(i))))) begin
                named_hit  = 1'b1;
                named_byte = xed_pkg::ent_value(xed_pkg::t_ent'(3'(i)));
            end
        end
        hexmode = (r_len > LW'(2)) && r_x2;
        cp_sel  = hexmode ? r_hex_val : r_dec_val;
        ovf_sel = hexmode ? r_hex_ovf : r_dec_ovf;
        bad_num = hexmode ? r_hex_bad : (r_dec_bad || r_len == LW'(1));
        if (cp_sel < CW'(8'h80)) begin
            cp_n = 3'd1;
        end else if (cp_sel < CW'(16'h0800)) begin
            cp_n = 3'd2;
        end else if (cp_sel < CW'(20'h10000)) begin
            cp_n = 3'd3;
        end else begin
            cp_n = 3'd4;
        end
        over_limit = ({1'b0, r_bytes_out} + 25'(cp_n)) > {1'b0, r_limit};
    end

    always_comb begin
        n_in_entity = r_in_entity;
        n_len       = r_len;
        n_match     = r_match;
        n_hash      = r_hash;
        n_x2        = r_x2;
        n_dec_bad   = r_dec_bad;
        n_dec_ovf   = r_dec_ovf;
        n_dec_val   = r_dec_val;
        n_hex_bad   = r_hex_bad;
        n_hex_ovf   = r_hex_ovf;
        n_hex_val   = r_hex_val;
        n_bytes_out = r_bytes_out;
        n_err       = r_err;
        cmd.cp      = '0;
        cmd.cnt     = 3'd0;
        cmd.fin     = 1'b0;
        cmd.status  = xed_pkg::ST_OK;

        if (accept) begin
            if (r_err == xed_pkg::ST_OK) begin
                if (r_in_entity) begin
                    if (c == xed_pkg::CH_SEMI) begin
                        n_in_entity = 1'b0;
                        n_len       = '0;
                        if (named_hit) begin
                            cmd.cp  = CW'(named_byte);
                            cmd.cnt = 3'd1;
                        end else if (r_len == '0 || !r_hash) begin
                            n_err = xed_pkg::ST_NAME;
                        end else if (bad_num) begin
                            n_err = xed_pkg::ST_NUMBER;
                        end else if (ovf_sel || cp_sel == '0 || cp_sel > xed_pkg::CP_MAX ||
                                     (cp_sel >= xed_pkg::SURR_LO &&
                                      cp_sel <= xed_pkg::SURR_HI)) begin
                            n_err = xed_pkg::ST_CODEPOINT;
                        end else if (over_limit) begin
                            n_err = xed_pkg::ST_LIMIT;
                        end else begin
                            cmd.cp  = cp_sel;
                            cmd.cnt = cp_n;
                        end
                    end else if (r_len >= LW'(xed_pkg::MAX_NAME_CHARS)) begin
                        n_err = xed_pkg::ST_ENTITY;
                    end else begin
                        n_len = r_len + LW'(1);
                        for (int i = 0; i < xed_pkg::NUM_NAMES; i++) begin
                            if (r_len < LW'(xed_pkg::ent_len(xed_pkg::t_ent'(3'(i))))) begin
                                n_match[i] = r_match[i] &&
                                    (c == xed_pkg::ent_char(xed_pkg::t_ent'(3'(i)),
                                                            r_len[1:0]));
                            end
                        end
                        if (r_len == LW'(0)) begin
                            n_hash = (c == xed_pkg::CH_HASH);
                        end
                        if (r_len == LW'(1)) begin
                            n_x2 = (c == xed_pkg::CH_XL) || (c == xed_pkg::CH_XU);
                        end
                        if (r_len != LW'(0)) begin
                            if (!dec_ok) begin
                                n_dec_bad = 1'b1;
                            end else if (!r_dec_ovf) begin
                                if (dec_sum > SW'(xed_pkg::CP_MAX)) begin
                                    n_dec_ovf = 1'b1;
                                    n_dec_val = xed_pkg::CP_SAT;
                                end else begin
                                    n_dec_val = dec_sum[CW-1:0];
                                end
                            end
                        end
                        if (r_len >= LW'(2)) begin
                            if (!hex_ok) begin
                                n_hex_bad = 1'b1;
                            end else if (!r_hex_ovf) begin
                                if (hex_sum > SW'(xed_pkg::CP_MAX)) begin
                                    n_hex_ovf = 1'b1;
                                    n_hex_val = xed_pkg::CP_SAT;
                                end else begin
                                    n_hex_val = hex_sum[CW-1:0];
                                end
                            end
                        end
                    end
                end else if (r_bytes_out >= r_limit) begin
                    n_err = xed_pkg::ST_LIMIT;
                end else if (c == xed_pkg::CH_AMP) begin
                    n_in_entity = 1'b1;
                    n_len       = '0;
                    n_match     = '1;
                    n_hash      = 1'b0;
                    n_x2        = 1'b0;
                    n_dec_bad   = 1'b0;
                    n_dec_ovf   = 1'b0;
                    n_dec_val   = '0;
                    n_hex_bad   = 1'b0;
                    n_hex_ovf   = 1'b0;
                    n_hex_val   = '0;
                end else begin
                    cmd.cp  = CW'(c);
                    cmd.cnt = 3'd1;
                end
                n_bytes_out = r_bytes_out + xed_pkg::LIMIT_W'(cmd.cnt);
            end

            if (i_in.last_byte) begin
                if (n_err == xed_pkg::ST_OK && n_in_entity) begin
                    n_err = xed_pkg::ST_ENTITY;
                end
                cmd.fin     = 1'b1;
                cmd.status  = n_err;
                n_in_entity = 1'b0;
                n_len       = '0;
                n_bytes_out = '0;
                n_err       = xed_pkg::ST_OK;
            end
        end
    end

    assign o_push = accept && (cmd.cnt != 3'd0 || cmd.fin);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_entity <= 1'b0;
            r_len       <= '0;
            r_match     <= '0;
            r_hash      <= 1'b0;
            r_x2        <= 1'b0;
            r_dec_bad   <= 1'b0;
            r_dec_ovf   <= 1'b0;
            r_dec_val   <= '0;
            r_hex_bad   <= 1'b0;
            r_hex_ovf   <= 1'b0;
            r_hex_val   <= '0;
            r_bytes_out <= '0;
            r_err       <= xed_pkg::ST_OK;
            r_limit     <= xed_pkg::LIMIT_RESET;
        end else begin
            r_in_entity <= n_in_entity;
            r_len       <= n_len;
            r_match     <= n_match;
            r_hash      <= n_hash;
            r_x2        <= n_x2;
            r_dec_bad   <= n_dec_bad;
            r_dec_ovf   <= n_dec_ovf;
            r_dec_val   <= n_dec_val;
            r_hex_bad   <= n_hex_bad;
            r_hex_ovf   <= n_hex_ovf;
            r_hex_val   <= n_hex_val;
            r_bytes_out <= n_bytes_out;
            r_err       <= n_err;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/xed_queue.sv @@
`default_nettype none
module xed_queue (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire xed_pkg::t_cmd                i_cmd,
    input  wire logic                         i_pop,
    output logic                              o_valid,
    output logic                              o_full,
    output logic [xed_pkg::QCNT_W-1:0]        o_count,
    output xed_pkg::t_cmd                     o_cmd
);

    localparam int PW = xed_pkg::QPTR_W;
    localparam int NW = xed_pkg::QCNT_W;

    xed_pkg::t_cmd r_mem [xed_pkg::QDEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [NW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == NW'(xed_pkg::QDEPTH));
    assign o_count = r_count;
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(xed_pkg::QDEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(xed_pkg::QDEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + NW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

@@ sv/xed_back.sv @@
`default_nettype none
module xed_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire xed_pkg::t_cmd  i_cmd,
    output logic                o_pop,
    xed_out_if.source           o_out
);

    logic [2:0]       r_idx, n_idx;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_is_data;
    logic             r_fin;
    xed_pkg::t_status r_status;

    logic       load;
    logic       last_res;
    logic       is_data;
    logic [2:0] total;

    // Each entry expands into its data bytes, then its status result if it closes a string.
    assign total    = i_cmd.cnt + 3'(i_cmd.fin);
    assign last_res = (r_idx + 3'd1) == total;
    assign is_data  = r_idx < i_cmd.cnt;
    assign load     = i_valid && (!r_valid || o_out.ready);
    assign o_pop    = load && last_res;

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = last_res ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_is_data <= is_data;
            r_fin     <= !is_data;
            r_byte    <= is_data ? xed_pkg::utf8_byte(i_cmd.cp, i_cmd.cnt, r_idx) : 8'h00;
            r_status  <= is_data ? xed_pkg::ST_OK : i_cmd.status;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_byte;
    assign o_out.is_data   = r_is_data;
    assign o_out.final_res = r_fin;
    assign o_out.status    = r_status;

endmodule
`default_nettype wire

@@ sv/xml_entity_decoder.sv @@
// Each result passes through the command queue and then the output register.
// Throughput: one input byte per cycle unless the command queue is full, and one
// result per cycle while the output is ready; an entity close emits up to four
// UTF-8 bytes plus the status result, and a four-entry command queue absorbs
// these bursts while input continues.
// Reset (synchronous, active low) clears the string state and the queue, and sets
// the output limit to 2097152 bytes.
`default_nettype none
module xml_entity_decoder (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [xed_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    xed_in_if.sink                            i_in,
    xed_out_if.source                         o_out
);

    logic                          q_push;
    logic                          q_pop;
    logic                          q_valid;
    logic                          q_full;
    logic [xed_pkg::QCNT_W-1:0]    q_count;
    xed_pkg::t_cmd                 push_cmd;
    xed_pkg::t_cmd                 head_cmd;

    xed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (push_cmd)
    );

    xed_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_count (q_count),
        .o_cmd   (head_cmd)
    );

    xed_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (head_cmd),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= xed_pkg::QCNT_W'(xed_pkg::QDEPTH))
        else $error("queue count beyond its depth");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.is_data) |-> (o_out.final_res && o_out.out_byte == 8'h00))
        else $error("status result without final flag or with a data byte");

    a_data_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_data) |-> (!o_out.final_res && o_out.status == 3'd0))
        else $error("data result carries status");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int IDLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 28;
    localparam int NUM_PHASES  = 8;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             is_data;
        logic             final_res;
        xed_pkg::t_status status;
    } t_dec_result;

    typedef struct {
        logic [7:0]       in_byte;
        bit               last;
        bit               typed;
        logic [7:0]       exp_byte;
        xed_pkg::t_status exp_status;
    } t_stim_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [xed_pkg::LIMIT_W-1:0] i_cfg_wdata;

    xed_in_if  in_ch ();
    xed_out_if out_ch ();

    xml_entity_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Decoder state as seen by the predictor.
    bit                          str_in_entity;
    logic [xed_pkg::LEN_W-1:0]   str_name_len;
    logic [7:0]                  str_name [xed_pkg::MAX_NAME_CHARS];
    logic [xed_pkg::LIMIT_W-1:0] str_bytes_out;
    xed_pkg::t_status            str_error;
    logic [xed_pkg::LIMIT_W-1:0] byte_limit;

    t_dec_result decoded_q [$];
    logic [7:0]  str_bytes [$];

    int err_count    = 0;
    int item_count   = 0;
    int string_count = 0;
    int check_count  = 0;
    bit no_idle      = 1'b0;

    string       entity_names [5] = '{"amp", "lt", "gt", "quot", "apos"};
    logic [31:0] cp_edges [16] = '{32'h0, 32'h1, 32'h7F, 32'h80, 32'h7FF, 32'h800,
                                   32'hD7FF, 32'hD800, 32'hDFFF, 32'hE000, 32'hFFFF,
                                   32'h10000, 32'h10FFFF, 32'h110000, 32'h1FFFFF,
                                   32'hFFFFFFF};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic clear_string();
        str_in_entity = 1'b0;
        str_name_len  = '0;
        str_bytes_out = '0;
        str_error     = xed_pkg::ST_OK;
    endtask

    task automatic queue_result(input t_dec_result r);
        decoded_q.insert(decoded_q.size(), r);
    endtask

    task automatic push_data(input logic [7:0] b);
        t_dec_result r;
        r = '{b, 1'b1, 1'b0, xed_pkg::ST_OK};
        queue_result(r);
        str_bytes_out = str_bytes_out + 1'b1;
    endtask

    function automatic bit name_matches(input string s);
        if (int'(str_name_len) != s.len()) return 1'b0;
        for (int i = 0; i < s.len(); i++) begin
            if (str_name[i] != s[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return 99;
    endfunction

    task automatic close_entity(output xed_pkg::t_status st);
        int                       base;
        int                       start;
        int                       n;
        int                       d;
        bit                       ovf;
        bit                       bad;
        logic [xed_pkg::CP_W-1:0] cp;
        logic [31:0]              acc;
        logic [7:0]               lead;
        st = xed_pkg::ST_OK;
        if (name_matches("amp")) begin
            push_data("&");
        end else if (name_matches("lt")) begin
            push_data("<");
        end else if (name_matches("gt")) begin
            push_data(">");
        end else if (name_matches("quot")) begin
            push_data(8'h22);
        end else if (name_matches("apos")) begin
            push_data(8'h27);
        end else if (str_name_len == 0 || str_name[0] != xed_pkg::CH_HASH) begin
            st = xed_pkg::ST_NAME;
        end else begin
            // A hex prefix only counts when a digit position follows it.
            if (str_name_len > 2 &&
                (str_name[1] == xed_pkg::CH_XL || str_name[1] == xed_pkg::CH_XU)) begin
                base  = 16;
                start = 2;
            end else begin
                base  = 10;
                start = 1;
            end
            cp  = '0;
            ovf = 1'b0;
            bad = (start >= int'(str_name_len));
            for (int i = start; i < int'(str_name_len) && !bad; i++) begin
                d = digit_of(str_name[i]);
                if (d >= base) begin
                    bad = 1'b1;
                end else if (!ovf) begin
                    acc = 32'(cp) * base + d;
                    if (acc > 32'(xed_pkg::CP_MAX)) begin
                        ovf = 1'b1;
                        cp  = xed_pkg::CP_SAT;
                    end else begin
                        cp = acc[xed_pkg::CP_W-1:0];
                    end
                end
            end
            if (bad) begin
                st = xed_pkg::ST_NUMBER;
            end else if (ovf || cp == 0 ||
                         (cp >= xed_pkg::SURR_LO && cp <= xed_pkg::SURR_HI)) begin
                st = xed_pkg::ST_CODEPOINT;
            end else begin
                n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
                if (32'(str_bytes_out) + n > 32'(byte_limit)) begin
                    st = xed_pkg::ST_LIMIT;
                end else if (n == 1) begin
                    push_data(cp[7:0]);
                end else begin
                    case (n)
                        2: begin
                            lead = 8'hC0;
                        end
                        3: begin
                            lead = 8'hE0;
                        end
                        default: begin
                            lead = 8'hF0;
                        end
                    endcase
                    push_data(lead | 8'(cp >> (6 * (n - 1))));
                    for (int k = n - 2; k >= 0; k--) begin
                        push_data(8'h80 | (8'(cp >> (6 * k)) & 8'h3F));
                    end
                end
            end
        end
    endtask

    task automatic predict_item(input logic [7:0] c, input bit last);
        xed_pkg::t_status st;
        t_dec_result      r;
        if (str_error == xed_pkg::ST_OK) begin
            if (str_in_entity) begin
                if (c == xed_pkg::CH_SEMI) begin
                    close_entity(st);
                    str_error     = st;
                    str_in_entity = 1'b0;
                    str_name_len  = '0;
                end else if (int'(str_name_len) >= xed_pkg::MAX_NAME_CHARS) begin
                    str_error = xed_pkg::ST_ENTITY;
                end else begin
                    str_name[str_name_len] = c;
                    str_name_len = str_name_len + 1'b1;
                end
            end else if (str_bytes_out >= byte_limit) begin
                str_error = xed_pkg::ST_LIMIT;
            end else if (c == xed_pkg::CH_AMP) begin
                str_in_entity = 1'b1;
                str_name_len  = '0;
            end else begin
                push_data(c);
            end
        end
        if (last) begin
            if (str_error == xed_pkg::ST_OK && str_in_entity) str_error = xed_pkg::ST_ENTITY;
            r = '{8'h00, 1'b0, 1'b1, str_error};
            queue_result(r);
            clear_string();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] pick_code();
        case ($urandom_range(0, 9))
            0: return cp_edges[$urandom_range(0, 15)];
            1: return $urandom_range(1, 32'h7F);
            2: return $urandom_range(32'h80, 32'h7FF);
            3: return $urandom_range(32'h800, 32'hFFFF);
            4: return $urandom_range(32'h10000, 32'h10FFFF);
            5: return $urandom_range(32'hD800, 32'hDFFF);
            6: return $urandom_range(32'h110000, 32'hFFFFFF);
            default: return $urandom_range(32'h20, 32'h7E);
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_digit();
        add_byte(8'(8'h30 + $urandom_range(0, 9)));
    endtask

    task automatic add_number();
        logic [31:0] v;
        bit          hex;
        string       digits;
        v   = pick_code();
        hex = $urandom_range(0, 1);
        if ($urandom_range(0, 9) == 0) begin
            // Long decimal strings drive the accumulator into saturation.
            digits = "";
            hex    = 1'b0;
            repeat ($urandom_range(8, 14)) begin
                digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
            end
        end else if (hex) begin
            digits = $urandom_range(0, 1) ? $sformatf("%0x", v) : $sformatf("%0X", v);
        end else begin
            digits = $sformatf("%0d", v);
        end
        if (!hex) begin
            add_text("&#");
        end else if ($urandom_range(0, 1)) begin
            add_text("&#x");
        end else begin
            add_text("&#X");
        end
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) add_byte("0");
        end
        add_text(digits);
        add_byte(xed_pkg::CH_SEMI);
    endtask

    task automatic add_bad_number();
        case ($urandom_range(0, 3))
            0: begin
                add_text("&#;");
            end
            1: begin
                if ($urandom_range(0, 1)) begin
                    add_text("&#x;");
                end else begin
                    add_text("&#X;");
                end
            end
            2: begin
                add_text("&#");
                if ($urandom_range(0, 1)) add_text("x");
                repeat ($urandom_range(0, 3)) add_digit();
                add_byte(8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 2)) add_digit();
                add_byte(xed_pkg::CH_SEMI);
            end
            default: begin
                add_text("&#x-1;");
            end
        endcase
    endtask

    task automatic add_named();
        string nm;
        int    pos;
        nm = entity_names[$urandom_range(0, 4)];
        add_byte(xed_pkg::CH_AMP);
        add_text(nm);
        if ($urandom_range(0, 6) == 0) begin
            pos = str_bytes.size() - 1 - $urandom_range(0, nm.len() - 1);
            str_bytes[pos] = 8'($urandom_range(0, 255));
        end
        add_byte(xed_pkg::CH_SEMI);
    endtask

    task automatic add_junk_entity();
        add_byte(xed_pkg::CH_AMP);
        repeat ($urandom_range(0, 17)) add_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) != 0) add_byte(xed_pkg::CH_SEMI);
    endtask

    task automatic build_string();
        str_bytes.delete();
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 19)) inside
                [0:5]: begin
                    repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(0, 255)));
                end
                [6:9]: begin
                    add_named();
                end
                [10:15]: begin
                    add_number();
                end
                [16:17]: begin
                    add_bad_number();
                end
                default: begin
                    add_junk_entity();
                end
            endcase
        end
    endtask

    // Called at a falling edge; returns at a falling edge after the item is taken.
    task automatic send_item(input logic [7:0] b, input bit last, input bit typed,
                             input logic [7:0] exp_byte,
                             input xed_pkg::t_status exp_status);
        int          first;
        int          gap;
        t_dec_result r;
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= b;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        first = decoded_q.size();
        predict_item(b, last);
        if (typed) begin
            for (int k = first; k < decoded_q.size(); k++) begin
                r = decoded_q[k];
                if (r.is_data) begin
                    r.out_byte = exp_byte;
                end else begin
                    r.status = exp_status;
                end
                decoded_q[k] = r;
            end
        end
        item_count++;
        @(negedge i_clk);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_string();
        no_idle = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < str_bytes.size(); i++) begin
            send_item(str_bytes[i], i == str_bytes.size() - 1, 1'b0, 8'h00, xed_pkg::ST_OK);
        end
        string_count++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge i_clk);
        repeat (IDLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_limit(input logic [xed_pkg::LIMIT_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        byte_limit  = v;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    initial begin
        int hold;
        hold         = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0) hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_dec_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            check_count++;
            if (decoded_q.size() == 0) begin
                $error("unexpected result: out_byte %0h is_data %0d final_res %0d status %0d",
                       out_ch.out_byte, out_ch.is_data, out_ch.final_res, out_ch.status);
                err_count++;
            end else begin
                want = decoded_q.pop_front();
                if (out_ch.out_byte !== want.out_byte) begin
                    $error("out_byte mismatch: expected %0h, actual %0h",
                           want.out_byte, out_ch.out_byte);
                    err_count++;
                end
                if (out_ch.is_data !== want.is_data) begin
                    $error("is_data mismatch: expected %0d, actual %0d",
                           want.is_data, out_ch.is_data);
                    err_count++;
                end
                if (out_ch.final_res !== want.final_res) begin
                    $error("final_res mismatch: expected %0d, actual %0d",
                           want.final_res, out_ch.final_res);
                    err_count++;
                end
                if (out_ch.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, out_ch.status);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        t_stim_row                   rows [26];
        logic [xed_pkg::LIMIT_W-1:0] phase_limits [NUM_PHASES];
        int                          phase_items;

        rows = '{
            '{8'h00,            1'b0, 1'b1, 8'h00, xed_pkg::ST_OK},
            '{8'hFF,            1'b1, 1'b1, 8'hFF, xed_pkg::ST_OK},
            '{xed_pkg::CH_AMP,  1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{"a",              1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{"m",              1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{"p",              1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{xed_pkg::CH_SEMI, 1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{xed_pkg::CH_AMP,  1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{xed_pkg::CH_HASH, 1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{xed_pkg::CH_XL,   1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{"E",              1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{"9",              1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{xed_pkg::CH_SEMI, 1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{xed_pkg::CH_AMP,  1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{xed_pkg::CH_HASH, 1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{xed_pkg::CH_XU,   1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{xed_pkg::CH_SEMI, 1'b1, 1'b1, 8'h00, xed_pkg::ST_NUMBER},
            '{xed_pkg::CH_AMP,  1'b1, 1'b1, 8'h00, xed_pkg::ST_ENTITY},
            '{xed_pkg::CH_AMP,  1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{"q",              1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{xed_pkg::CH_SEMI, 1'b1, 1'b1, 8'h00, xed_pkg::ST_NAME},
            '{xed_pkg::CH_AMP,  1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{xed_pkg::CH_HASH, 1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{"0",              1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{xed_pkg::CH_SEMI, 1'b0, 1'b0, 8'h00, xed_pkg::ST_OK},
            '{"Z",              1'b1, 1'b1, 8'h00, xed_pkg::ST_CODEPOINT}
        };
        phase_limits = '{xed_pkg::LIMIT_RESET, 24'd0, 24'd1, 24'd3,
                         24'($urandom_range(2, 12)), 24'hFFFFFF, 24'($urandom), 24'd6};

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        in_ch.valid     = 1'b0;
        in_ch.in_byte   = 8'h00;
        in_ch.last_byte = 1'b0;
        clear_string();
        byte_limit = xed_pkg::LIMIT_RESET;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed strings run with the limit left at its reset value.
        foreach (rows[i]) begin
            send_item(rows[i].in_byte, rows[i].last, rows[i].typed,
                      rows[i].exp_byte, rows[i].exp_status);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            set_limit(phase_limits[p]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                // Once, let the output drain completely before the next string.
                if (p == 0 && string_count == 3) wait_idle();
                build_string();
                phase_items += str_bytes.size();
                send_string();
            end
        end

        no_idle = 1'b0;
        wait_idle();

        $display("Sent %0d bytes in %0d strings over %0d output limit settings.",
                 item_count, string_count, NUM_PHASES);
        $display("Checked %0d results: named, decimal and hex entities plus error paths.",
                 check_count);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/xed_pkg.sv
sv/xed_in_if.sv
sv/xed_out_if.sv
sv/xed_front.sv
sv/xed_queue.sv
sv/xed_back.sv
sv/xml_entity_decoder.sv
tb/tb.sv
